@@ rtl/abff_pkg.sv @@
// Shared types and constants of the allocation bitmap with first-free search.
package abff_pkg;

  localparam int WORD_W     = 64;
  localparam int OFF_W      = 6;
  localparam int INDEX_W    = 12;
  localparam int WADDR_W    = INDEX_W - OFF_W;
  localparam int LIMIT_W    = 13;
  localparam int INDEX_SPAN = 4096;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] REG_SEARCH_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET      = 13'd4096;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_CLR  = 2'd1,
    CMD_TEST = 2'd2,
    CMD_FIND = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] clr_word;
    logic              bit_val;
    logic              zero_found;
    logic [OFF_W-1:0]  zero_pos;
  } word_res_t;

endpackage

@@ rtl/abff_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module abff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/abff_word_unit.sv @@
// Shared word unit: bit update, bit test and lowest-free-bit search in one map word.
module abff_word_unit
  import abff_pkg::*;
(
  input  logic [WORD_W-1:0]  word,
  input  logic [OFF_W-1:0]   bit_off,
  input  logic [LIMIT_W-1:0] rem,
  output word_res_t          res
);

  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] lim_mask;
  logic [WORD_W-1:0] free_vec;

  always_comb begin
    logic [WORD_W-1:0] v;
    logic [OFF_W-1:0]  pos;
    bit_mask = WORD_W'(1) << bit_off;
    if (rem >= LIMIT_W'(WORD_W)) begin
      lim_mask = '1;
    end else begin
      lim_mask = (WORD_W'(1) << rem[OFF_W-1:0]) - WORD_W'(1);
    end
    free_vec = ~word & lim_mask;
    v   = free_vec;
    pos = '0;
    for (int l = OFF_W - 1; l >= 0; l--) begin
      if ((v & ((WORD_W'(1) << (1 << l)) - WORD_W'(1))) == '0) begin
        pos[l] = 1'b1;
        v      = v >> (1 << l);
      end
    end
    res.set_word   = word | bit_mask;
    res.clr_word   = word & ~bit_mask;
    res.bit_val    = word[bit_off];
    res.zero_found = |free_vec;
    res.zero_pos   = pos;
  end

endmodule

@@ rtl/allocation_bitmap_first_free_top.sv @@
// Top level of the allocation bitmap: command sequencer, map storage and register port.
//
// The map holds one bit per block, 0 free and 1 used, in 64-bit words; every word
// starts out free after reset through per-word valid flags, so no clearing pass is
// needed. A transaction is taken when start is high and busy is low. Set, clear and
// test do one RAM read, then the update or test; a set, clear or test with an index
// beyond the map answers without a RAM read, and find scans one 64-bit word at a time,
// up to ceil(min(search_limit, MAP_BITS, 4096) / 64) words; the scan rate is set by
// the single RAM read port feeding the shared word unit. The result is shown for one
// cycle with out_valid and cannot be held off by the receiver.
module allocation_bitmap_first_free_top
  import abff_pkg::*;
#(
  parameter int MAP_BITS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [INDEX_W-1:0]    in_bit_index,
  output logic                  out_valid,
  output logic                  out_bit_value,
  output logic [INDEX_W-1:0]    out_free_index,
  output logic                  out_found,
  output logic                  out_index_error,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int USED_BITS = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
  localparam int DEPTH     = (USED_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN
  } state_t;

  state_t               state_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [LIMIT_W-1:0]   lim_r;
  logic [WADDR_W:0]     n_words_r;
  logic [WADDR_W-1:0]   scan_w_r;
  logic [INDEX_W-1:0]   idx_r;
  cmd_t                 cmd_r;
  logic [DEPTH-1:0]     valid_r;
  logic                 out_valid_r;
  logic                 out_bit_value_r;
  logic [INDEX_W-1:0]   out_free_index_r;
  logic                 out_found_r;
  logic                 out_index_error_r;

  logic                 accept;
  logic                 idx_bad;
  logic [LIMIT_W-1:0]   lim_in;
  logic [LIMIT_W-1:0]   lim_words;
  logic [WADDR_W-1:0]   in_word;
  logic [WADDR_W-1:0]   cur_w;
  logic [WADDR_W-1:0]   rd_w;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    cur_word;
  logic [LIMIT_W-1:0]   rem;
  logic                 scan_last;
  word_res_t            wres;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SEARCH_LIMIT) ? APB_DATA_W'(limit_r) : '0;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_bad = (32'(in_bit_index) >= MAP_BITS);
  assign lim_in  = (limit_r > LIMIT_W'(USED_BITS)) ? LIMIT_W'(USED_BITS) : limit_r;
  assign lim_words = lim_in + LIMIT_W'(WORD_W - 1);
  assign in_word = in_bit_index[INDEX_W-1:OFF_W];

  assign cur_w     = (state_r == ST_MODIFY) ? idx_r[INDEX_W-1:OFF_W] : scan_w_r;
  assign rd_w      = (state_r == ST_SCAN) ? (scan_w_r + WADDR_W'(1)) :
                     ((cmd_t'(in_command) == CMD_FIND) ? '0 : in_word);
  assign cur_word  = valid_r[AW'(cur_w)] ? ram_rdata : '0;
  assign rem       = lim_r - LIMIT_W'({scan_w_r, {OFF_W{1'b0}}});
  assign scan_last = (({1'b0, scan_w_r} + (WADDR_W + 1)'(1)) == n_words_r);

  assign ram_we    = (state_r == ST_MODIFY) && ((cmd_r == CMD_SET) || (cmd_r == CMD_CLR));
  assign ram_wdata = (cmd_r == CMD_SET) ? wres.set_word : wres.clr_word;

  abff_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx_r[INDEX_W-1:OFF_W])),
    .wdata (ram_wdata),
    .raddr (AW'(rd_w)),
    .rdata (ram_rdata)
  );

  abff_word_unit u_word (
    .word    (cur_word),
    .bit_off (idx_r[OFF_W-1:0]),
    .rem     (rem),
    .res     (wres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_SEARCH_LIMIT)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r             <= cmd_t'(in_command);
            idx_r             <= in_bit_index;
            lim_r             <= lim_in;
            n_words_r         <= lim_words[LIMIT_W-1:OFF_W];
            scan_w_r          <= '0;
            out_bit_value_r   <= 1'b0;
            out_free_index_r  <= '0;
            out_found_r       <= 1'b0;
            out_index_error_r <= 1'b0;
            if (cmd_t'(in_command) == CMD_FIND) begin
              if (lim_in == '0) begin
                out_valid_r <= 1'b1;
              end else begin
                state_r <= ST_SCAN;
              end
            end else if (idx_bad) begin
              out_index_error_r <= 1'b1;
              out_valid_r       <= 1'b1;
            end else begin
              state_r <= ST_MODIFY;
            end
          end
        end
        ST_MODIFY: begin
          if (ram_we) begin
            valid_r[AW'(idx_r[INDEX_W-1:OFF_W])] <= 1'b1;
          end
          out_bit_value_r <= (cmd_r == CMD_TEST) ? wres.bit_val : 1'b0;
          out_valid_r     <= 1'b1;
          state_r         <= ST_IDLE;
        end
        ST_SCAN: begin
          if (wres.zero_found) begin
            out_found_r      <= 1'b1;
            out_free_index_r <= {scan_w_r, wres.zero_pos};
            out_valid_r      <= 1'b1;
            state_r          <= ST_IDLE;
          end else if (scan_last) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            scan_w_r <= scan_w_r + WADDR_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_value_r;
  assign out_free_index  = out_free_index_r;
  assign out_found       = out_found_r;
  assign out_index_error = out_index_error_r;

endmodule
